@@ hw/rtl/pcm_byte_to_sample_unpack_top_macros.svh @@
// assertion macros for the pcm sample unpacker
`ifndef PCM_BYTE_TO_SAMPLE_UNPACK_TOP_MACROS_SVH
`define PCM_BYTE_TO_SAMPLE_UNPACK_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define PCMUNPK_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcmunpk: same-cycle check failed");

// next-cycle implication, checked out of reset
`define PCMUNPK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcmunpk: next-cycle check failed");

`endif

@@ hw/rtl/pcmunpk_pkg.sv @@
// package: types and constants of the pcm sample unpacker
`default_nettype none
package pcmunpk_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned PART_W     = 24;
  localparam int unsigned BPS_W      = 3;
  localparam int unsigned CHCNT_W    = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_SAMPLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LITTLE_ENDIAN    = 2'd2;

  // reset values of the registers
  localparam logic [BPS_W-1:0]   BPS_RESET   = 3'd2;
  localparam logic [CHCNT_W-1:0] CHCNT_RESET = 2'd2;
  localparam logic               LE_RESET    = 1'b1;

  localparam logic [CHCNT_W-1:0] CHCNT_MONO   = 2'd1;
  localparam logic [CHCNT_W-1:0] CHCNT_STEREO = 2'd2;

  localparam logic [BYTE_W-1:0] SIGN_FLIP = 8'h80;

  typedef struct packed {
    logic [BPS_W-1:0]   bytes_per_sample;
    logic [CHCNT_W-1:0] channel_count;
    logic               little_endian;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              mono;
    logic              channel;
    logic [WORD_W-1:0] word;
  } res_t;

endpackage
`default_nettype wire

@@ hw/rtl/pcmunpk_in_if.sv @@
// byte input channel of the pcm sample unpacker
`default_nettype none
interface pcmunpk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink (input valid, input data_byte, input restart, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/pcmunpk_out_if.sv @@
// sample output channel of the pcm sample unpacker
`default_nettype none
interface pcmunpk_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_word;
  logic               channel;
  logic               last;

  modport source (output valid, output sample_word, output channel, output last,
                  input ready);
  modport sink (input valid, input sample_word, input channel, input last,
                output ready);
endinterface
`default_nettype wire

@@ hw/rtl/pcmunpk_asm.sv @@
// sample assembler: byte position, partial sample and channel state
`default_nettype none
module pcmunpk_asm
  import pcmunpk_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              byte_valid,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              restart,
  input  wire logic              take,
  output res_t                   res
);

  logic [1:0]        pos_r, pos_nxt, pos_eff;
  logic [PART_W-1:0] part_r, part_nxt, part_eff;
  logic              nch_r, nch_nxt, nch_eff;
  logic              supported;
  logic              complete;
  logic [BPS_W-1:0]  last_pos;
  logic [WORD_W-1:0] word;

  always_comb begin
    pos_eff  = restart ? 2'd0 : pos_r;
    part_eff = restart ? '0 : part_r;
    nch_eff  = restart ? 1'b0 : nch_r;

    supported = (cfg.bytes_per_sample >= 3'd1) && (cfg.bytes_per_sample <= 3'd4) &&
                ((cfg.channel_count == CHCNT_MONO) || (cfg.channel_count == CHCNT_STEREO));
    last_pos  = cfg.bytes_per_sample - 3'd1;
    complete  = ({1'b0, pos_eff} >= last_pos);

    // held bytes sit in arrival order, first byte in the low bits
    word = '0;
    unique case (cfg.bytes_per_sample)
      3'd1: begin
        word = {data_byte, 24'h0};
        if (cfg.little_endian) word[WORD_W-1 -: BYTE_W] = data_byte ^ SIGN_FLIP;
      end
      3'd2: word = cfg.little_endian ? {data_byte, part_eff[7:0], 16'h0}
                                     : {part_eff[7:0], data_byte, 16'h0};
      3'd3: word = cfg.little_endian ? {data_byte, part_eff[15:8], part_eff[7:0], 8'h0}
                                     : {part_eff[7:0], part_eff[15:8], data_byte, 8'h0};
      3'd4: word = cfg.little_endian
                   ? {data_byte, part_eff[23:16], part_eff[15:8], part_eff[7:0]}
                   : {part_eff[7:0], part_eff[15:8], part_eff[23:16], data_byte};
      default: word = '0;
    endcase

    res.valid   = byte_valid && supported && complete;
    res.mono    = (cfg.channel_count == CHCNT_MONO);
    res.channel = res.mono ? 1'b0 : nch_eff;
    res.word    = word;

    pos_nxt  = pos_eff;
    part_nxt = part_eff;
    nch_nxt  = nch_eff;
    if (supported) begin
      if (complete) begin
        pos_nxt  = 2'd0;
        part_nxt = '0;
        nch_nxt  = res.mono ? 1'b0 : ~nch_eff;
      end else begin
        pos_nxt = pos_eff + 2'd1;
        unique case (pos_eff)
          2'd0:    part_nxt[7:0]   = data_byte;
          2'd1:    part_nxt[15:8]  = data_byte;
          2'd2:    part_nxt[23:16] = data_byte;
          default: part_nxt        = part_eff;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 2'd0;
      part_r <= '0;
      nch_r  <= 1'b0;
    end else if (take) begin
      pos_r  <= pos_nxt;
      part_r <= part_nxt;
      nch_r  <= nch_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/pcmunpk_outq.sv @@
// result register: holds one sample and replays mono samples as right
`default_nettype none
`include "pcm_byte_to_sample_unpack_top_macros.svh"
module pcmunpk_outq
  import pcmunpk_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire res_t     res,
  input  wire logic     load,
  output logic          can_load,
  pcmunpk_out_if.source out_ch
);

  logic              valid_r, valid_nxt;
  logic              dup_r, dup_nxt;
  logic              chan_r, chan_nxt;
  logic              last_r, last_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic              fire;

  assign fire     = valid_r && out_ch.ready;
  assign can_load = !valid_r || (out_ch.ready && !dup_r);

  always_comb begin
    valid_nxt = valid_r;
    dup_nxt   = dup_r;
    chan_nxt  = chan_r;
    last_nxt  = last_r;
    word_nxt  = word_r;
    if (fire) begin
      if (dup_r) begin
        // mono: same word again as the right channel
        dup_nxt  = 1'b0;
        chan_nxt = 1'b1;
        last_nxt = 1'b1;
      end else begin
        valid_nxt = 1'b0;
      end
    end
    if (load && res.valid) begin
      valid_nxt = 1'b1;
      dup_nxt   = res.mono;
      chan_nxt  = res.channel;
      last_nxt  = !res.mono;
      word_nxt  = res.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dup_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      dup_r   <= dup_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chan_r <= chan_nxt;
    last_r <= last_nxt;
    word_r <= word_nxt;
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.sample_word = $signed(word_r);
  assign out_ch.channel     = chan_r;
  assign out_ch.last        = last_r;

  `PCMUNPK_ASSERT_NOW(a_dup_needs_valid, dup_r, valid_r)
  `PCMUNPK_ASSERT_NOW(a_notlast_is_dup, valid_r && !last_r, dup_r && !chan_r)
  `PCMUNPK_ASSERT_NEXT(a_dup_replays_right, fire && dup_r,
                       valid_r && chan_r && last_r && $stable(word_r))

endmodule
`default_nettype wire

@@ hw/rtl/pcm_byte_to_sample_unpack_top.sv @@
// PCM byte-to-sample unpacker: takes one raw byte per item and puts out
// left-justified 32-bit samples, 8/16/24/32 bit, big or little endian, mono
// duplicated to left then right. A byte can be taken every cycle unless its
// sample waits for the result register; it passes the input register, then
// the result register. A mono sample holds the result register until its
// right copy is sent. The user must write configuration only while no item
// is in flight; the block itself does not enforce it.
`default_nettype none
module pcm_byte_to_sample_unpack_top
  import pcmunpk_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  pcmunpk_in_if.sink                 in_ch,
  pcmunpk_out_if.source              out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg_r;
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_restart_r;
  res_t              res;
  logic              can_load;
  logic              advance;
  logic              in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bytes_per_sample <= BPS_RESET;
      cfg_r.channel_count    <= CHCNT_RESET;
      cfg_r.little_endian    <= LE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BYTES_PER_SAMPLE: cfg_r.bytes_per_sample <= cfg_data[BPS_W-1:0];
        REG_CHANNEL_COUNT:    cfg_r.channel_count    <= cfg_data[CHCNT_W-1:0];
        REG_LITTLE_ENDIAN:    cfg_r.little_endian    <= cfg_data[0];
        default:              cfg_r                  <= cfg_r;
      endcase
    end
  end

  // a byte that makes no sample moves on even while the output stalls
  assign advance     = s1_valid_r && (!res.valid || can_load);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r    <= in_ch.data_byte;
      s1_restart_r <= in_ch.restart;
    end
  end

  pcmunpk_asm u_asm (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .byte_valid (s1_valid_r),
    .data_byte  (s1_byte_r),
    .restart    (s1_restart_r),
    .take       (advance),
    .res        (res)
  );

  pcmunpk_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .load     (advance),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

@@ tb/sv/tb_pcm_byte_to_sample_unpack_top.sv @@
// testbench for the pcm byte-to-sample unpacker: directed table, then random phases
module tb_pcm_byte_to_sample_unpack_top;
  import pcmunpk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES   = 1550;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRINT_LIMIT    = 40;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    val;
    logic [BYTE_W-1:0]        data_byte;
    logic                     restart;
    logic                     pinned;
    logic [WORD_W-1:0]        word;
  } row_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              channel;
    logic              last;
  } sample_t;

  localparam int N_DIRECTED = 41;
  localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // reset format: 16-bit little-endian stereo
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'h80, 1'b0, 1'b1, 32'h8000_0000},
    // 8-bit mono: unsigned, then signed with little endian off
    '{ROW_CFG,  REG_BYTES_PER_SAMPLE, 3'd1, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG,  REG_CHANNEL_COUNT,    3'd1, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'h00, 1'b0, 1'b1, 32'h8000_0000},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'hff, 1'b0, 1'b1, 32'h7f00_0000},
    '{ROW_CFG,  REG_LITTLE_ENDIAN,    3'd0, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'h80, 1'b0, 1'b1, 32'h8000_0000},
    // 32-bit stereo, both byte orders
    '{ROW_CFG,  REG_BYTES_PER_SAMPLE, 3'd4, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG,  REG_CHANNEL_COUNT,    3'd2, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'h7f, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'hff, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'hff, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'hff, 1'b0, 1'b1, 32'h7fff_ffff},
    '{ROW_CFG,  REG_LITTLE_ENDIAN,    3'd1, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'h80, 1'b0, 1'b1, 32'h8000_0000},
    // 32-bit mono duplicates too
    '{ROW_CFG,  REG_CHANNEL_COUNT,    3'd1, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'hff, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'hff, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'hff, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'h7f, 1'b0, 1'b1, 32'h7fff_ffff},
    // width lowered with two bytes held
    '{ROW_CFG,  REG_BYTES_PER_SAMPLE, 3'd3, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG,  REG_CHANNEL_COUNT,    3'd2, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'h12, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'h34, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG,  REG_BYTES_PER_SAMPLE, 3'd2, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'h56, 1'b0, 1'b0, 32'h0},
    // unsupported formats drop the byte, restart still clears
    '{ROW_CFG,  REG_BYTES_PER_SAMPLE, 3'd0, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'haa, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG,  REG_BYTES_PER_SAMPLE, 3'd7, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'hab, 1'b1, 1'b0, 32'h0},
    '{ROW_CFG,  REG_BYTES_PER_SAMPLE, 3'd2, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG,  REG_CHANNEL_COUNT,    3'd3, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'hcd, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG,  REG_CHANNEL_COUNT,    3'd2, 8'h00, 1'b0, 1'b0, 32'h0},
    // restart in the middle of a sample
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'h11, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'h22, 1'b1, 1'b0, 32'h0},
    '{ROW_BYTE, REG_BYTES_PER_SAMPLE, 3'd0, 8'h33, 1'b0, 1'b0, 32'h0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pcmunpk_in_if  in_ch ();
  pcmunpk_out_if out_ch ();

  pcm_byte_to_sample_unpack_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // format and unpacking state as the testbench sees it
  logic [BPS_W-1:0]   fmt_bytes;
  logic [CHCNT_W-1:0] fmt_chans;
  logic               fmt_le;
  logic [1:0]         held_count;
  logic [PART_W-1:0]  held_bytes;
  logic               stereo_side;

  sample_t pending_samples [$];
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  int      stall_left = 0;
  int      free_run = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // returns a gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // assemble samples from one accepted byte, queue the results it should give
  function void unpack_byte(input logic [BYTE_W-1:0] db, input logic rs,
                            input logic pinned, input logic [WORD_W-1:0] pinned_word);
    logic [BYTE_W-1:0] b [4];
    logic [WORD_W-1:0] w;
    int n;
    if (rs) begin
      held_count = '0;
      held_bytes = '0;
      stereo_side = 1'b0;
    end
    n = int'(fmt_bytes);
    if (n < 1 || n > 4 || (fmt_chans != CHCNT_MONO && fmt_chans != CHCNT_STEREO)) return;
    if (held_count < n - 1) begin
      held_bytes[8*held_count +: 8] = db;
      held_count = held_count + 2'd1;
      return;
    end
    // width may have dropped while bytes were held: only the first n-1 count
    for (int i = 0; i < n - 1; i++) b[i] = held_bytes[8*i +: 8];
    b[n-1] = db;
    w = '0;
    for (int i = 0; i < n; i++) begin
      if (fmt_le) w = w | ({24'h0, b[i]} << (32 - 8*(n - i)));
      else        w = w | ({24'h0, b[i]} << (24 - 8*i));
    end
    if (n == 1 && fmt_le) w = w ^ {SIGN_FLIP, 24'h0};
    if (pinned) w = pinned_word;
    held_count = '0;
    held_bytes = '0;
    if (fmt_chans == CHCNT_MONO) begin
      pending_samples.push_back('{word: w, channel: 1'b0, last: 1'b0});
      pending_samples.push_back('{word: w, channel: 1'b1, last: 1'b1});
      stereo_side = 1'b0;
    end else begin
      pending_samples.push_back('{word: w, channel: stereo_side, last: 1'b1});
      stereo_side = ~stereo_side;
    end
  endfunction

  task automatic report(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("tb: mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] db, input logic rs, input logic pinned,
                           input logic [WORD_W-1:0] pinned_word, input bit steady);
    int gap;
    @(negedge clk);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data_byte = db;
    in_ch.restart = rs;
    do @(posedge clk); while (!in_ch.ready);
    unpack_byte(db, rs, pinned, pinned_word);
  endtask

  // hold the sender until every queued sample is out and the pipe is empty
  task automatic drain_block();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    case (idx)
      REG_BYTES_PER_SAMPLE: fmt_bytes = val[BPS_W-1:0];
      REG_CHANNEL_COUNT:    fmt_chans = val[CHCNT_W-1:0];
      REG_LITTLE_ENDIAN:    fmt_le = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // result side: random stalls, with occasional long stretches of none
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (free_run > 0) begin
      out_ch.ready = 1'b1;
      free_run--;
    end else begin
      out_ch.ready = 1'b1;
      stall_left = pick_gap();
      if ($urandom_range(0, 199) == 0) free_run = $urandom_range(50, 200);
    end
  end

  always @(posedge clk) begin
    sample_t want;
    logic [WORD_W-1:0] got_word;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_word = out_ch.sample_word;
      if (pending_samples.size() == 0) begin
        report($sformatf("sample %h ch %0d with nothing expected", got_word, out_ch.channel));
      end else begin
        want = pending_samples.pop_front();
        if (got_word !== want.word)
          report($sformatf("sample_word %h, expected %h", got_word, want.word));
        if (out_ch.channel !== want.channel)
          report($sformatf("channel %0d, expected %0d", out_ch.channel, want.channel));
        if (out_ch.last !== want.last)
          report($sformatf("last %0d, expected %0d", out_ch.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int phase;
    int len;
    bit ok_fmt;
    bit steady;
    logic [BPS_W-1:0]   bps;
    logic [CHCNT_W-1:0] chans;
    logic               le;
    logic               prev_cfg;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.restart = 1'b0;
    out_ch.ready = 1'b0;
    fmt_bytes = BPS_RESET;
    fmt_chans = CHCNT_RESET;
    fmt_le = LE_RESET;
    held_count = '0;
    held_bytes = '0;
    stereo_side = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    prev_cfg = 1'b0;
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
        if (!prev_cfg) drain_block();
        write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].val);
      end else begin
        send_byte(DIRECTED_ROWS[i].data_byte, DIRECTED_ROWS[i].restart,
                  DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].word, 1'b0);
      end
      prev_cfg = (DIRECTED_ROWS[i].kind == ROW_CFG);
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_BYTES) begin
      // first phases hit the format extremes, then mostly legal random formats
      case (phase)
        0: begin bps = 3'd1; chans = CHCNT_MONO;   le = 1'b1; end
        1: begin bps = 3'd4; chans = CHCNT_STEREO; le = 1'b0; end
        2: begin bps = 3'd1; chans = CHCNT_STEREO; le = 1'b0; end
        3: begin bps = 3'd4; chans = CHCNT_MONO;   le = 1'b1; end
        default: begin
          if ($urandom_range(0, 9) < 8) begin
            bps = BPS_W'($urandom_range(1, 4));
            chans = CHCNT_W'($urandom_range(1, 2));
          end else begin
            bps = BPS_W'($urandom_range(0, 7));
            chans = CHCNT_W'($urandom_range(0, 3));
          end
          le = 1'($urandom_range(0, 1));
        end
      endcase
      ok_fmt = (bps >= 1 && bps <= 4) && (chans == CHCNT_MONO || chans == CHCNT_STEREO);
      drain_block();
      write_reg(REG_BYTES_PER_SAMPLE, bps);
      write_reg(REG_CHANNEL_COUNT, {1'b0, chans});
      write_reg(REG_LITTLE_ENDIAN, {2'b00, le});
      len = ok_fmt ? $urandom_range(30, 90) : 8;
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        if (k == len / 2 && (phase == 0 || $urandom_range(0, 7) == 0)) drain_block();
        send_byte(BYTE_W'($urandom_range(0, 255)), ($urandom_range(0, 99) < 3), 1'b0, '0,
                  steady);
      end
      if (ok_fmt) sent += len;
      phase++;
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/pcmunpk_pkg.sv
hw/rtl/pcmunpk_in_if.sv
hw/rtl/pcmunpk_out_if.sv
hw/rtl/pcmunpk_asm.sv
hw/rtl/pcmunpk_outq.sv
hw/rtl/pcm_byte_to_sample_unpack_top.sv
tb/sv/tb_pcm_byte_to_sample_unpack_top.sv
